// ===== rtl/adts_to_flv_audio_repacker_top_assert.svh =====
// ----------------------------------------------------------------------------
// adts to flv repacker assertion macros
// concurrent checks, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ADTS_TO_FLV_AUDIO_REPACKER_TOP_ASSERT_SVH
`define ADTS_TO_FLV_AUDIO_REPACKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define A2FLV_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("a2flv check failed");
`define A2FLV_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("a2flv check failed");
`else
`define A2FLV_ASSERT_IMP(label, clk, rst, ante, cons)
`define A2FLV_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/a2flv_pkg.sv =====
// ----------------------------------------------------------------------------
// a2flv_pkg
// shared types and constants of the adts to flv audio repacker
// ----------------------------------------------------------------------------
package a2flv_pkg;

  localparam int unsigned PFX_LEN   = 13;
  localparam int unsigned PFX_IDX_W = $clog2(PFX_LEN);
  localparam logic [PFX_IDX_W-1:0] PFX_LAST = PFX_IDX_W'(PFX_LEN - 1);

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_AUDIO_TAG  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_STEP = CFG_IDX_W'(1);

  localparam logic [7:0]  AUDIO_TAG_RST  = 8'd175;
  localparam logic [15:0] FRAME_STEP_RST = 16'd23;

  localparam logic [7:0] FLV_TAG_AUDIO  = 8'h08;
  localparam logic [7:0] AAC_RAW_MARK   = 8'h01;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_buffer;
    logic        last_of_buffer;
    logic [31:0] buffer_pts;
  } src_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_packet;
    logic       truncated;
  } dst_word_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_PFX  = 1'b1
  } desc_kind_t;

  // one pending piece of output: a payload byte or a whole prefix
  typedef struct packed {
    desc_kind_t  kind;
    logic [7:0]  data_byte;
    logic        last;
    logic        trunc;
    logic [23:0] body_size;
    logic [31:0] ts;
  } desc_t;

  typedef struct packed {
    logic pending;
    logic done;
  } em_status_t;

endpackage

// ===== rtl/a2flv_emitter.sv =====
// ----------------------------------------------------------------------------
// a2flv_emitter
// holds one descriptor and serialises it into output words
// ----------------------------------------------------------------------------
module a2flv_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          audio_tag_byte,
  input  logic                load,
  input  a2flv_pkg::desc_t    desc_in,
  output a2flv_pkg::em_status_t status,
  output logic                dst_valid,
  input  logic                dst_stall,
  output a2flv_pkg::dst_word_t dst_data
);

  logic                             d_valid;
  a2flv_pkg::desc_t                 desc;
  logic [a2flv_pkg::PFX_IDX_W-1:0] idx;
  logic                             out_load;
  logic                             d_done;
  logic [7:0]                       pfx_bytes [a2flv_pkg::PFX_LEN];
  a2flv_pkg::dst_word_t             word;

  assign out_load = !dst_valid || !dst_stall;
  assign d_done   = d_valid && out_load &&
                    (desc.kind == a2flv_pkg::KIND_DATA || idx == a2flv_pkg::PFX_LAST);

  // pending first, then done
  assign status = {d_valid, d_done};

  always_comb begin
    pfx_bytes[0]  = a2flv_pkg::FLV_TAG_AUDIO;
    pfx_bytes[1]  = desc.body_size[23:16];
    pfx_bytes[2]  = desc.body_size[15:8];
    pfx_bytes[3]  = desc.body_size[7:0];
    pfx_bytes[4]  = desc.ts[23:16];
    pfx_bytes[5]  = desc.ts[15:8];
    pfx_bytes[6]  = desc.ts[7:0];
    pfx_bytes[7]  = desc.ts[31:24];
    pfx_bytes[8]  = 8'h00;
    pfx_bytes[9]  = 8'h00;
    pfx_bytes[10] = 8'h00;
    pfx_bytes[11] = audio_tag_byte;
    pfx_bytes[12] = a2flv_pkg::AAC_RAW_MARK;
  end

  always_comb begin
    case (desc.kind)
      a2flv_pkg::KIND_PFX: begin
        word.out_byte       = pfx_bytes[idx];
        word.last_of_packet = (idx == a2flv_pkg::PFX_LAST) && desc.last;
        word.truncated      = 1'b0;
      end
      default: begin
        word.out_byte       = desc.data_byte;
        word.last_of_packet = desc.last;
        word.truncated      = desc.trunc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      idx       <= '0;
      dst_valid <= 1'b0;
    end else begin
      if (out_load) begin
        dst_valid <= d_valid;
      end
      if (d_valid && out_load) begin
        idx <= d_done ? '0 : idx + 1'b1;
      end
      if (load) begin
        d_valid <= 1'b1;
      end else if (d_done) begin
        d_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc <= desc_in;
    end
    if (out_load && d_valid) begin
      dst_data <= word;
    end
  end

endmodule

// ===== rtl/adts_to_flv_audio_repacker_top.sv =====
// ----------------------------------------------------------------------------
// adts_to_flv_audio_repacker_top
// cuts an adts aac byte stream into frames and emits flv audio packets
// ----------------------------------------------------------------------------
// datapath: a taken byte is held in the emitter descriptor register, then in the dst output register
// throughput: one byte per cycle unless dst stalls; a frame prefix is sent as
//   13 output bytes from the descriptor register, during which src is stalled
// reset: synchronous rst clears framing state, timestamp and output valids,
//   and loads the register defaults (tag byte 175, frame step 23)
module adts_to_flv_audio_repacker_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                src_valid,
  output logic                                src_stall,
  input  a2flv_pkg::src_word_t                src_data,
  output logic                                dst_valid,
  input  logic                                dst_stall,
  output a2flv_pkg::dst_word_t                dst_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [a2flv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                         cfg_data
);

  `include "adts_to_flv_audio_repacker_top_assert.svh"

  logic [7:0]  audio_tag_byte;
  logic [15:0] frame_step;

  logic [12:0] byte_position, bp_next;
  logic [12:0] frame_length, fl_next;
  logic [3:0]  header_bytes, hb_next;
  logic [31:0] running_pts, rp_next;
  logic        discard_rest, dr_next;

  logic        src_acc;
  logic [12:0] pos;
  logic        dr_start;
  logic [31:0] rp_start;
  logic        hdr_end;
  logic        pay_end;
  logic        desc_emit;
  logic        desc_load;
  a2flv_pkg::desc_t      desc_new;
  a2flv_pkg::em_status_t em_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_tag_byte <= a2flv_pkg::AUDIO_TAG_RST;
      frame_step     <= a2flv_pkg::FRAME_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        a2flv_pkg::REG_AUDIO_TAG:  audio_tag_byte <= cfg_data[7:0];
        a2flv_pkg::REG_FRAME_STEP: frame_step     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign src_stall = em_stat.pending && !em_stat.done;
  assign src_acc   = src_valid && !src_stall;

  // a new buffer restarts framing and loads its timestamp
  assign pos      = src_data.first_of_buffer ? 13'd0 : byte_position;
  assign dr_start = src_data.first_of_buffer ? 1'b0 : discard_rest;
  assign rp_start = src_data.first_of_buffer ? src_data.buffer_pts : running_pts;

  always_comb begin
    bp_next   = pos;
    fl_next   = frame_length;
    hb_next   = header_bytes;
    rp_next   = rp_start;
    dr_next   = dr_start;
    desc_emit = 1'b0;
    hdr_end   = 1'b0;
    pay_end   = 1'b0;

    desc_new.kind      = a2flv_pkg::KIND_DATA;
    desc_new.data_byte = src_data.data_byte;
    desc_new.last      = 1'b0;
    desc_new.trunc     = 1'b0;
    desc_new.body_size = 24'(frame_length) - 24'(header_bytes) + 24'd2;
    desc_new.ts        = rp_start;

    if (!dr_start) begin
      case (pos)
        13'd1: hb_next = src_data.data_byte[0] ? 4'd7 : 4'd9;
        13'd3: fl_next = {src_data.data_byte[1:0], 11'b0};
        13'd4: fl_next = frame_length | {2'b0, src_data.data_byte, 3'b0};
        13'd5: begin
          fl_next = frame_length | {10'b0, src_data.data_byte[7:5]};
          if (fl_next < {9'b0, hb_next}) begin
            dr_next = 1'b1;
          end
        end
        default: ;
      endcase

      if (!dr_next) begin
        hdr_end = (pos >= 13'd6) && (hb_next != 4'd0) &&
                  (pos == {9'b0, hb_next} - 13'd1);
        pay_end = ({1'b0, pos} + 14'd1) >= {1'b0, fl_next};
        if (hdr_end) begin
          desc_new.kind = a2flv_pkg::KIND_PFX;
          desc_new.last = (fl_next == {9'b0, hb_next});
          if (!src_data.last_of_buffer) begin
            desc_emit = 1'b1;
            rp_next   = rp_start + {16'b0, frame_step};
          end
          bp_next = desc_new.last ? 13'd0 : pos + 13'd1;
        end else if (pos >= 13'd7 && pos >= {9'b0, hb_next}) begin
          // payload byte passes straight through
          desc_emit      = 1'b1;
          desc_new.last  = pay_end || src_data.last_of_buffer;
          desc_new.trunc = src_data.last_of_buffer && !pay_end;
          bp_next        = pay_end ? 13'd0 : pos + 13'd1;
        end else begin
          bp_next = pos + 13'd1;
        end
      end
    end

    if (src_data.last_of_buffer) begin
      dr_next = 1'b1;
      bp_next = 13'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      frame_length  <= '0;
      header_bytes  <= '0;
      running_pts   <= '0;
      discard_rest  <= 1'b0;
    end else if (src_acc) begin
      byte_position <= bp_next;
      frame_length  <= fl_next;
      header_bytes  <= hb_next;
      running_pts   <= rp_next;
      discard_rest  <= dr_next;
    end
  end

  assign desc_load = src_acc && desc_emit;

  a2flv_emitter u_emitter (
    .clk            (clk),
    .rst            (rst),
    .audio_tag_byte (audio_tag_byte),
    .load           (desc_load),
    .desc_in        (desc_new),
    .status         (em_stat),
    .dst_valid      (dst_valid),
    .dst_stall      (dst_stall),
    .dst_data       (dst_data)
  );

  `A2FLV_ASSERT_IMP(a_stall_only_pending, clk, rst, src_stall, em_stat.pending)
  `A2FLV_ASSERT_IMP(a_discard_silent, clk, rst, src_acc && discard_rest && !src_data.first_of_buffer, !desc_emit)
  `A2FLV_ASSERT_NXT(a_last_closes_buffer, clk, rst, src_acc && src_data.last_of_buffer, discard_rest && byte_position == 13'd0)

endmodule
